// ----- rtl/core/spct_pkg.sv -----
package spct_pkg;

    localparam int SQ_STEPS  = 32;
    localparam int DIV_STEPS = 15;
    localparam int NUM_W     = 47;
    localparam logic [14:0] ONE_Q14 = 15'd16384;

    typedef struct packed {
        logic        box_box;
        logic        neg;
        logic        dbl;
        logic        sgn_x;
        logic        sgn_y;
        logic [31:0] mag_x;
        logic [31:0] mag_y;
        logic [31:0] rad;
        logic        disc_hit;
        logic        near;
        logic [30:0] disc_pen;
        logic        bb_hit;
        logic        bb_on_x;
        logic        bb_pos;
        logic [30:0] bb_pen;
        logic [1:0]  trig;
        logic [31:0] tag;
    } ctx_t;

endpackage

// ----- rtl/core/spct_prep.sv -----
module spct_prep (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  shape_a,
    input  logic signed [31:0]    center_ax,
    input  logic signed [31:0]    center_ay,
    input  logic [30:0]           extent_aw,
    input  logic [30:0]           extent_ah,
    input  logic                  shape_b,
    input  logic signed [31:0]    center_bx,
    input  logic signed [31:0]    center_by,
    input  logic [30:0]           extent_bw,
    input  logic [30:0]           extent_bh,
    input  logic [1:0]            trigger_flags,
    input  logic [31:0]           pair_tag,
    output logic                  out_valid,
    output spct_pkg::ctx_t        out_ctx,
    output logic [63:0]           out_sq
);
    import spct_pkg::*;

    // stage 1
    logic               v1_reg;
    logic               bb1_reg, neg1_reg, dbl1_reg;
    logic signed [32:0] dx1_reg, dy1_reg;
    logic signed [33:0] cx1_reg, cy1_reg;
    logic signed [34:0] lox1_reg, hix1_reg, loy1_reg, hiy1_reg;
    logic [31:0]        rad1_reg, sw1_reg, sh1_reg;
    logic [1:0]         trig1_reg;
    logic [31:0]        tag1_reg;

    logic signed [31:0] box_x, box_y, cir_x, cir_y;
    logic [30:0]        box_w, box_h, cir_r;

    always_comb
    begin
        if (shape_a == 1'b0)
        begin
            box_x = center_ax; box_y = center_ay; box_w = extent_aw; box_h = extent_ah;
            cir_x = center_bx; cir_y = center_by; cir_r = extent_bw;
        end
        else
        begin
            box_x = center_bx; box_y = center_by; box_w = extent_bw; box_h = extent_bh;
            cir_x = center_ax; cir_y = center_ay; cir_r = extent_aw;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else
            v1_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        bb1_reg  <= ~shape_a & ~shape_b;
        neg1_reg <= shape_a & ~shape_b;
        dbl1_reg <= shape_a ^ shape_b;
        dx1_reg  <= 33'(center_bx) - 33'(center_ax);
        dy1_reg  <= 33'(center_by) - 33'(center_ay);
        cx1_reg  <= 34'(cir_x) <<< 1;
        cy1_reg  <= 34'(cir_y) <<< 1;
        lox1_reg <= (35'(box_x) <<< 1) - 35'(signed'({1'b0, box_w}));
        hix1_reg <= (35'(box_x) <<< 1) + 35'(signed'({1'b0, box_w}));
        loy1_reg <= (35'(box_y) <<< 1) - 35'(signed'({1'b0, box_h}));
        hiy1_reg <= (35'(box_y) <<< 1) + 35'(signed'({1'b0, box_h}));
        rad1_reg <= (shape_a & shape_b) ? 32'(extent_aw) + 32'(extent_bw)
                                        : {cir_r, 1'b0};
        sw1_reg  <= 32'(extent_aw) + 32'(extent_bw);
        sh1_reg  <= 32'(extent_ah) + 32'(extent_bh);
        trig1_reg <= trigger_flags;
        tag1_reg  <= pair_tag;
    end

    // stage 2
    logic signed [36:0] off_x, off_y;
    logic [35:0]        mx, my;
    logic [33:0]        adx2, ady2;
    logic [31:0]        ox, oy;
    logic               on_x;

    always_comb
    begin
        if (!dbl1_reg)
        begin
            off_x = 37'(dx1_reg);
            off_y = 37'(dy1_reg);
        end
        else
        begin
            if (35'(cx1_reg) < lox1_reg)
                off_x = 37'(cx1_reg) - 37'(lox1_reg);
            else if (35'(cx1_reg) > hix1_reg)
                off_x = 37'(cx1_reg) - 37'(hix1_reg);
            else
                off_x = '0;
            if (35'(cy1_reg) < loy1_reg)
                off_y = 37'(cy1_reg) - 37'(loy1_reg);
            else if (35'(cy1_reg) > hiy1_reg)
                off_y = 37'(cy1_reg) - 37'(hiy1_reg);
            else
                off_y = '0;
        end
        mx   = off_x[36] ? 36'(-off_x) : off_x[35:0];
        my   = off_y[36] ? 36'(-off_y) : off_y[35:0];
        adx2 = dx1_reg[32] ? 34'(-dx1_reg) << 1 : 34'(dx1_reg) << 1;
        ady2 = dy1_reg[32] ? 34'(-dy1_reg) << 1 : 34'(dy1_reg) << 1;
        ox   = sw1_reg - adx2[31:0];
        oy   = sh1_reg - ady2[31:0];
        on_x = ox < oy;
    end

    logic        v2_reg;
    logic [35:0] mx2_reg, my2_reg;
    ctx_t        ctx2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        mx2_reg           <= mx;
        my2_reg           <= my;
        ctx2_reg.box_box  <= bb1_reg;
        ctx2_reg.neg      <= neg1_reg;
        ctx2_reg.dbl      <= dbl1_reg;
        ctx2_reg.sgn_x    <= off_x[36];
        ctx2_reg.sgn_y    <= off_y[36];
        ctx2_reg.mag_x    <= mx[31:0];
        ctx2_reg.mag_y    <= my[31:0];
        ctx2_reg.rad      <= rad1_reg;
        ctx2_reg.disc_hit <= 1'b0;
        ctx2_reg.near     <= 1'b0;
        ctx2_reg.disc_pen <= '0;
        ctx2_reg.bb_hit   <= ({2'b00, sw1_reg} > adx2) && ({2'b00, sh1_reg} > ady2);
        ctx2_reg.bb_on_x  <= on_x;
        ctx2_reg.bb_pos   <= on_x ? (!dx1_reg[32] && dx1_reg != '0)
                                  : (!dy1_reg[32] && dy1_reg != '0);
        ctx2_reg.bb_pen   <= on_x ? ox[31:1] : oy[31:1];
        ctx2_reg.trig     <= trig1_reg;
        ctx2_reg.tag      <= tag1_reg;
    end

    // stage 3
    logic        v3_reg, lt3_reg;
    logic [63:0] px3_reg, py3_reg, r23_reg;
    ctx_t        ctx3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        lt3_reg  <= (mx2_reg < 36'(ctx2_reg.rad)) && (my2_reg < 36'(ctx2_reg.rad));
        px3_reg  <= 64'(ctx2_reg.mag_x) * 64'(ctx2_reg.mag_x);
        py3_reg  <= 64'(ctx2_reg.mag_y) * 64'(ctx2_reg.mag_y);
        r23_reg  <= 64'(ctx2_reg.rad) * 64'(ctx2_reg.rad);
        ctx3_reg <= ctx2_reg;
    end

    // stage 4
    logic [64:0] sum3;
    logic        v4_reg;
    logic [63:0] sq4_reg;
    ctx_t        ctx4_reg;
    ctx_t        ctx4_next;

    assign sum3 = 65'(px3_reg) + 65'(py3_reg);

    always_comb
    begin
        ctx4_next          = ctx3_reg;
        ctx4_next.disc_hit = lt3_reg && (sum3 < {1'b0, r23_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else
            v4_reg <= v3_reg;
    end

    always_ff @(posedge clk)
    begin
        sq4_reg  <= sum3[63:0];
        ctx4_reg <= ctx4_next;
    end

    assign out_valid = v4_reg;
    assign out_ctx   = ctx4_reg;
    assign out_sq    = sq4_reg;

endmodule

// ----- rtl/core/spct_isqrt.sv -----
module spct_isqrt (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  spct_pkg::ctx_t  in_ctx,
    input  logic [63:0]     in_sq,
    output logic            out_valid,
    output spct_pkg::ctx_t  out_ctx,
    output logic [31:0]     out_root
);
    import spct_pkg::*;

    logic        valid_reg [1:SQ_STEPS];
    logic [63:0] rem_reg   [1:SQ_STEPS];
    logic [63:0] res_reg   [1:SQ_STEPS];
    ctx_t        ctx_reg   [1:SQ_STEPS];

    genvar k;
    generate
        for (k = 0; k < SQ_STEPS; k++)
        begin : g_step
            localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
            logic        v_in;
            logic [63:0] rem_in, res_in, trial, rem_next, res_next;
            ctx_t        ctx_in;

            if (k == 0)
            begin : g_first
                assign v_in   = in_valid;
                assign rem_in = in_sq;
                assign res_in = '0;
                assign ctx_in = in_ctx;
            end
            else
            begin : g_rest
                assign v_in   = valid_reg[k];
                assign rem_in = rem_reg[k];
                assign res_in = res_reg[k];
                assign ctx_in = ctx_reg[k];
            end

            always_comb
            begin
                trial = res_in + BIT;
                if (rem_in >= trial)
                begin
                    rem_next = rem_in - trial;
                    res_next = (res_in >> 1) + BIT;
                end
                else
                begin
                    rem_next = rem_in;
                    res_next = res_in >> 1;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    valid_reg[k+1] <= 1'b0;
                else
                    valid_reg[k+1] <= v_in;
            end

            always_ff @(posedge clk)
            begin
                rem_reg[k+1] <= rem_next;
                res_reg[k+1] <= res_next;
                ctx_reg[k+1] <= ctx_in;
            end
        end
    endgenerate

    assign out_valid = valid_reg[SQ_STEPS];
    assign out_ctx   = ctx_reg[SQ_STEPS];
    assign out_root  = res_reg[SQ_STEPS][31:0];

endmodule

// ----- rtl/core/spct_div.sv -----
module spct_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  spct_pkg::ctx_t       in_ctx,
    input  logic [46:0]          num_x,
    input  logic [46:0]          num_y,
    input  logic [31:0]          den,
    output logic                 out_valid,
    output spct_pkg::ctx_t       out_ctx,
    output logic [14:0]          quo_x,
    output logic [14:0]          quo_y
);
    import spct_pkg::*;

    logic              valid_reg [1:DIV_STEPS];
    logic [NUM_W-1:0]  rx_reg    [1:DIV_STEPS];
    logic [NUM_W-1:0]  ry_reg    [1:DIV_STEPS];
    logic [14:0]       qx_reg    [1:DIV_STEPS];
    logic [14:0]       qy_reg    [1:DIV_STEPS];
    logic [31:0]       den_reg   [1:DIV_STEPS];
    ctx_t              ctx_reg   [1:DIV_STEPS];

    genvar k;
    generate
        for (k = 0; k < DIV_STEPS; k++)
        begin : g_step
            localparam int SH = DIV_STEPS - 1 - k;
            logic             v_in;
            logic [NUM_W-1:0] rx_in, ry_in, dsh;
            logic [14:0]      qx_in, qy_in, qx_next, qy_next;
            logic [31:0]      den_in;
            ctx_t             ctx_in;

            if (k == 0)
            begin : g_first
                assign v_in   = in_valid;
                assign rx_in  = num_x;
                assign ry_in  = num_y;
                assign qx_in  = '0;
                assign qy_in  = '0;
                assign den_in = den;
                assign ctx_in = in_ctx;
            end
            else
            begin : g_rest
                assign v_in   = valid_reg[k];
                assign rx_in  = rx_reg[k];
                assign ry_in  = ry_reg[k];
                assign qx_in  = qx_reg[k];
                assign qy_in  = qy_reg[k];
                assign den_in = den_reg[k];
                assign ctx_in = ctx_reg[k];
            end

            assign dsh     = NUM_W'(den_in) << SH;
            assign qx_next = qx_in | (15'(rx_in >= dsh) << SH);
            assign qy_next = qy_in | (15'(ry_in >= dsh) << SH);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    valid_reg[k+1] <= 1'b0;
                else
                    valid_reg[k+1] <= v_in;
            end

            always_ff @(posedge clk)
            begin
                rx_reg[k+1]  <= (rx_in >= dsh) ? rx_in - dsh : rx_in;
                ry_reg[k+1]  <= (ry_in >= dsh) ? ry_in - dsh : ry_in;
                qx_reg[k+1]  <= qx_next;
                qy_reg[k+1]  <= qy_next;
                den_reg[k+1] <= den_in;
                ctx_reg[k+1] <= ctx_in;
            end
        end
    endgenerate

    assign out_valid = valid_reg[DIV_STEPS];
    assign out_ctx   = ctx_reg[DIV_STEPS];
    assign quo_x     = qx_reg[DIV_STEPS];
    assign quo_y     = qy_reg[DIV_STEPS];

endmodule

// ----- rtl/core/shape_pair_contact_test_top.sv -----
// channel   | signals                                 | direction
// ----------+-----------------------------------------+----------
// command   | start, busy, shape/center/extent, tags  | in (busy: out)
// result    | done, hit, normal, penetration, tag_out | out
//
// One transaction enters per cycle; busy never rises.
// The pipeline has 4 setup stages, 32 square-root stages (one root bit each),
// 1 stage to form the numerators, 15 divider stages and 1 output stage.
// Reset clears all valid bits; in-flight transactions are dropped.
// done marks one cycle of result; the receiver cannot stall.
module shape_pair_contact_test_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               shape_a,
    input  logic signed [31:0] center_ax,
    input  logic signed [31:0] center_ay,
    input  logic [30:0]        extent_aw,
    input  logic [30:0]        extent_ah,
    input  logic               shape_b,
    input  logic signed [31:0] center_bx,
    input  logic signed [31:0] center_by,
    input  logic [30:0]        extent_bw,
    input  logic [30:0]        extent_bh,
    input  logic [1:0]         trigger_flags,
    input  logic [31:0]        pair_tag,
    output logic               done,
    output logic               hit,
    output logic signed [15:0] normal_x,
    output logic signed [15:0] normal_y,
    output logic [30:0]        penetration,
    output logic               is_trigger,
    output logic [31:0]        tag_out
);
    import spct_pkg::*;

    localparam logic [33:0] EPS_RAW =
        34'(((64'd1 << FRAC_BITS) + 64'd500) / 64'd1000);

    assign busy = 1'b0;

    logic        pv;
    ctx_t        pctx;
    logic [63:0] psq;

    spct_prep u_prep (
        .clk, .rst_n, .in_valid(start),
        .shape_a, .center_ax, .center_ay, .extent_aw, .extent_ah,
        .shape_b, .center_bx, .center_by, .extent_bw, .extent_bh,
        .trigger_flags, .pair_tag,
        .out_valid(pv), .out_ctx(pctx), .out_sq(psq)
    );

    logic        sv;
    ctx_t        sctx;
    logic [31:0] root;

    spct_isqrt u_isqrt (
        .clk, .rst_n, .in_valid(pv), .in_ctx(pctx), .in_sq(psq),
        .out_valid(sv), .out_ctx(sctx), .out_root(root)
    );

    logic        qv_reg;
    ctx_t        qctx_reg;
    ctx_t        qctx_next;
    logic [46:0] nx_reg, ny_reg;
    logic [31:0] dist_reg;
    logic [31:0] pen_raw;

    assign pen_raw = (sctx.rad - root) >> sctx.dbl;

    always_comb
    begin
        qctx_next          = sctx;
        qctx_next.near     = {2'b00, root} <= (sctx.dbl ? EPS_RAW << 1 : EPS_RAW);
        qctx_next.disc_pen = pen_raw[31] ? '1 : pen_raw[30:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            qv_reg <= 1'b0;
        else
            qv_reg <= sv;
    end

    always_ff @(posedge clk)
    begin
        nx_reg   <= {1'b0, sctx.mag_x, 14'b0} + 47'(root >> 1);
        ny_reg   <= {1'b0, sctx.mag_y, 14'b0} + 47'(root >> 1);
        dist_reg <= root;
        qctx_reg <= qctx_next;
    end

    logic        dv;
    ctx_t        dctx;
    logic [14:0] qx, qy;

    spct_div u_div (
        .clk, .rst_n, .in_valid(qv_reg), .in_ctx(qctx_reg),
        .num_x(nx_reg), .num_y(ny_reg), .den(dist_reg),
        .out_valid(dv), .out_ctx(dctx), .quo_x(qx), .quo_y(qy)
    );

    logic [14:0]        mgx, mgy;
    logic signed [15:0] nx, ny;
    logic               h;
    logic [30:0]        pen;

    always_comb
    begin
        mgx = (qx > ONE_Q14) ? ONE_Q14 : qx;
        mgy = (qy > ONE_Q14) ? ONE_Q14 : qy;
        if (dctx.box_box)
        begin
            h   = dctx.bb_hit;
            pen = dctx.bb_pen;
            nx  = '0;
            ny  = '0;
            if (dctx.bb_on_x)
                nx = dctx.bb_pos ? 16'(ONE_Q14) : -16'(ONE_Q14);
            else
                ny = dctx.bb_pos ? 16'(ONE_Q14) : -16'(ONE_Q14);
        end
        else
        begin
            h   = dctx.disc_hit;
            pen = dctx.disc_pen;
            if (dctx.near)
            begin
                nx = 16'(ONE_Q14);
                ny = '0;
            end
            else
            begin
                nx = dctx.sgn_x ? -16'(mgx) : 16'(mgx);
                ny = dctx.sgn_y ? -16'(mgy) : 16'(mgy);
            end
            if (dctx.neg)
            begin
                nx = -nx;
                ny = -ny;
            end
        end
    end

    logic               done_reg, hit_reg, trig_reg;
    logic signed [15:0] nx_out_reg, ny_out_reg;
    logic [30:0]        pen_out_reg;
    logic [31:0]        tag_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= dv;
    end

    always_ff @(posedge clk)
    begin
        hit_reg     <= h;
        nx_out_reg  <= h ? nx : '0;
        ny_out_reg  <= h ? ny : '0;
        pen_out_reg <= h ? pen : '0;
        trig_reg    <= h && (dctx.trig != 2'b00);
        tag_out_reg <= dctx.tag;
    end

    assign done        = done_reg;
    assign hit         = hit_reg;
    assign normal_x    = nx_out_reg;
    assign normal_y    = ny_out_reg;
    assign penetration = pen_out_reg;
    assign is_trigger  = trig_reg;
    assign tag_out     = tag_out_reg;

    a_miss_clean: assert property (@(posedge clk) disable iff (!rst_n)
        done && !hit |-> normal_x == 16'sd0 && normal_y == 16'sd0 && penetration == '0)
        else $error("miss carries contact data");

    a_hit_normal: assert property (@(posedge clk) disable iff (!rst_n)
        done && hit |-> normal_x != 16'sd0 || normal_y != 16'sd0)
        else $error("hit with zero normal");

    a_trig_hit: assert property (@(posedge clk) disable iff (!rst_n)
        done && is_trigger |-> hit)
        else $error("trigger without hit");

    a_bb_axis: assert property (@(posedge clk) disable iff (!rst_n)
        dv && dctx.box_box && dctx.bb_hit |=> normal_x == 16'sd0 || normal_y == 16'sd0)
        else $error("box pair normal off axis");

endmodule

// ----- sim/contact_checker.sv -----
module contact_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic               shape_a,
    input  logic signed [31:0] center_ax,
    input  logic signed [31:0] center_ay,
    input  logic [30:0]        extent_aw,
    input  logic [30:0]        extent_ah,
    input  logic               shape_b,
    input  logic signed [31:0] center_bx,
    input  logic signed [31:0] center_by,
    input  logic [30:0]        extent_bw,
    input  logic [30:0]        extent_bh,
    input  logic [1:0]         trigger_flags,
    input  logic [31:0]        pair_tag,
    input  logic               done,
    input  logic               hit,
    input  logic signed [15:0] normal_x,
    input  logic signed [15:0] normal_y,
    input  logic [30:0]        penetration,
    input  logic               is_trigger,
    input  logic [31:0]        tag_out,
    output int                 fail_count,
    output int                 in_flight
);

    localparam int          FRAC = 16;
    localparam longint      UNIT = 16384;
    localparam bit [63:0]   EPS_Q = ((64'd1 << FRAC) + 64'd500) / 64'd1000;
    localparam bit [63:0]   DEPTH_MAX = 64'h7FFF_FFFF;

    typedef struct {
        bit               hit;
        bit signed [15:0] nx;
        bit signed [15:0] ny;
        bit [30:0]        depth;
        bit               trig;
        bit [31:0]        tag;
    } contact_res_t;

    contact_res_t expected_contacts[$];

    function automatic bit [63:0] abs64(input longint v);
        return v < 0 ? 64'd0 - 64'(v) : 64'(v);
    endfunction

    function automatic bit [63:0] floor_root(input bit [63:0] v);
        bit [63:0] res;
        bit [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic bit signed [15:0] unit_comp(input longint d, input bit [63:0] span);
        bit [63:0] m;
        m = (abs64(d) * 64'd16384 + span / 2) / span;
        if (m > 64'd16384)
            m = 64'd16384;
        return d < 0 ? -16'(m) : 16'(m);
    endfunction

    function automatic contact_res_t disc_contact(input longint ddx, input longint ddy,
                                                  input bit [63:0] rad, input int s);
        contact_res_t c;
        bit [63:0] ax, ay, sq, root_len, d;
        c = '{default: 0};
        ax = abs64(ddx);
        ay = abs64(ddy);
        if (ax >= rad || ay >= rad)
            return c;
        sq = ax * ax + ay * ay;
        if (sq < ax * ax)
            return c;
        if (sq >= rad * rad)
            return c;
        root_len = floor_root(sq);
        c.hit = 1;
        if (root_len > (EPS_Q << s))
        begin
            c.nx = unit_comp(ddx, root_len);
            c.ny = unit_comp(ddy, root_len);
        end
        else
        begin
            c.nx = 16'(UNIT);
            c.ny = 0;
        end
        d = (rad - root_len) >> s;
        c.depth = d > DEPTH_MAX ? 31'(DEPTH_MAX) : 31'(d);
        return c;
    endfunction

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic contact_res_t box_disc_contact(input longint bx, input longint by,
                                                      input longint bw, input longint bh,
                                                      input longint cx, input longint cy,
                                                      input longint r);
        longint px, py;
        px = clip(2 * cx, 2 * bx - bw, 2 * bx + bw);
        py = clip(2 * cy, 2 * by - bh, 2 * by + bh);
        return disc_contact(2 * cx - px, 2 * cy - py, 64'(2 * r), 1);
    endfunction

    function automatic contact_res_t box_box_contact(input longint dx, input longint dy,
                                                     input bit [63:0] sw, input bit [63:0] sh);
        contact_res_t c;
        bit [63:0] adx2, ady2, ox, oy, d;
        c = '{default: 0};
        adx2 = 2 * abs64(dx);
        ady2 = 2 * abs64(dy);
        if (!(adx2 < sw && ady2 < sh))
            return c;
        ox = sw - adx2;
        oy = sh - ady2;
        c.hit = 1;
        if (ox < oy)
        begin
            c.nx = dx > 0 ? 16'(UNIT) : -16'(UNIT);
            d = ox >> 1;
        end
        else
        begin
            c.ny = dy > 0 ? 16'(UNIT) : -16'(UNIT);
            d = oy >> 1;
        end
        c.depth = d > DEPTH_MAX ? 31'(DEPTH_MAX) : 31'(d);
        return c;
    endfunction

    function automatic contact_res_t predict_contact();
        contact_res_t c;
        longint ax, ay, bx, by, aw, ah, bw, bh;
        ax = center_ax;
        ay = center_ay;
        bx = center_bx;
        by = center_by;
        aw = longint'(extent_aw);
        ah = longint'(extent_ah);
        bw = longint'(extent_bw);
        bh = longint'(extent_bh);
        if (!shape_a && !shape_b)
            c = box_box_contact(bx - ax, by - ay, 64'(aw + bw), 64'(ah + bh));
        else if (shape_a && shape_b)
            c = disc_contact(bx - ax, by - ay, 64'(aw + bw), 0);
        else if (!shape_a)
            c = box_disc_contact(ax, ay, aw, ah, bx, by, bw);
        else
        begin
            c = box_disc_contact(bx, by, bw, bh, ax, ay, aw);
            c.nx = -c.nx;
            c.ny = -c.ny;
        end
        if (!c.hit)
            c = '{default: 0};
        c.trig = c.hit && trigger_flags != 0;
        c.tag = pair_tag;
        return c;
    endfunction

    initial fail_count = 0;

    always @(posedge clk)
    begin
        contact_res_t e;
        if (rst_n)
        begin
            if (start && !busy)
                expected_contacts = {expected_contacts, predict_contact()};
            if (done)
            begin
                if (expected_contacts.size() == 0)
                begin
                    $display("%0t: result with no transaction pending, tag %h", $time, tag_out);
                    fail_count++;
                end
                else
                begin
                    e = expected_contacts.pop_front();
                    if (hit !== e.hit)
                    begin
                        $display("%0t: hit expected %0d actual %0d", $time, e.hit, hit);
                        fail_count++;
                    end
                    if (normal_x !== e.nx)
                    begin
                        $display("%0t: normal_x expected %0d actual %0d", $time, e.nx, normal_x);
                        fail_count++;
                    end
                    if (normal_y !== e.ny)
                    begin
                        $display("%0t: normal_y expected %0d actual %0d", $time, e.ny, normal_y);
                        fail_count++;
                    end
                    if (penetration !== e.depth)
                    begin
                        $display("%0t: penetration expected %h actual %h",
                                 $time, e.depth, penetration);
                        fail_count++;
                    end
                    if (is_trigger !== e.trig)
                    begin
                        $display("%0t: is_trigger expected %0d actual %0d",
                                 $time, e.trig, is_trigger);
                        fail_count++;
                    end
                    if (tag_out !== e.tag)
                    begin
                        $display("%0t: tag_out expected %h actual %h", $time, e.tag, tag_out);
                        fail_count++;
                    end
                end
            end
        end
        in_flight = expected_contacts.size();
    end

endmodule

// ----- sim/shape_pair_contact_test_top_tb.sv -----
module shape_pair_contact_test_top_tb;

    localparam int RANDOM_PAIRS = 750;
    localparam int STALL_LIMIT  = 2000;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic               shape_a;
    logic signed [31:0] center_ax;
    logic signed [31:0] center_ay;
    logic [30:0]        extent_aw;
    logic [30:0]        extent_ah;
    logic               shape_b;
    logic signed [31:0] center_bx;
    logic signed [31:0] center_by;
    logic [30:0]        extent_bw;
    logic [30:0]        extent_bh;
    logic [1:0]         trigger_flags;
    logic [31:0]        pair_tag;
    logic               done;
    logic               hit;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic [30:0]        penetration;
    logic               is_trigger;
    logic [31:0]        tag_out;
    int                 fail_count;
    int                 in_flight;
    int                 idle_cycles;
    int                 burst_left;

    shape_pair_contact_test_top i_dut (.*);

    contact_checker i_checker (.*);

    initial
    begin
        clk = 0;
        forever
        begin
            #4 clk = 1;
            #4 clk = 0;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("FAIL shape_pair_contact_test_top");
            $finish;
        end
    end

    task automatic send_pair(input int sa, input int ax, input int ay, input int aw,
                             input int ah, input int sb, input int bx, input int by,
                             input int bw, input int bh);
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
            gap = 0;
        end
        else
        begin
            gap = $urandom_range(0, 5);
            if ($urandom_range(0, 15) == 0)
                burst_left = $urandom_range(10, 40);
        end
        @(negedge clk);
        if (gap > 0)
        begin
            start = 0;
            repeat (gap - 1) @(negedge clk);
            @(negedge clk);
        end
        start = 1;
        shape_a = sa[0];
        center_ax = ax;
        center_ay = ay;
        extent_aw = aw[30:0];
        extent_ah = ah[30:0];
        shape_b = sb[0];
        center_bx = bx;
        center_by = by;
        extent_bw = bw[30:0];
        extent_bh = bh[30:0];
        trigger_flags = 2'($urandom_range(0, 3));
        pair_tag = $urandom;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    function automatic int scaled_rand(input int max_bits);
        int k;
        k = $urandom_range(0, max_bits);
        return k == 32 ? int'($urandom) : int'($urandom & ((33'd1 << k) - 1));
    endfunction

    task automatic send_random_pair();
        int ax, ay, bx, by;
        if ($urandom_range(0, 9) == 0)
        begin
            send_pair($urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom, $urandom);
            return;
        end
        ax = scaled_rand(32);
        ay = scaled_rand(32);
        bx = ax + ($urandom_range(0, 1) ? scaled_rand(24) : -scaled_rand(24));
        by = ay + ($urandom_range(0, 1) ? scaled_rand(24) : -scaled_rand(24));
        send_pair($urandom, ax, ay, scaled_rand(26), scaled_rand(26),
                  $urandom, bx, by, scaled_rand(26), scaled_rand(26));
    endtask

    localparam int MAXE = 32'h7FFF_FFFF;
    localparam int MINC = 32'h8000_0000;
    localparam int ONE  = 32'h0001_0000;

    initial
    begin
        rst_n = 0;
        start = 0;
        shape_a = 0;
        center_ax = 0;
        center_ay = 0;
        extent_aw = 0;
        extent_ah = 0;
        shape_b = 0;
        center_bx = 0;
        center_by = 0;
        extent_bw = 0;
        extent_bh = 0;
        trigger_flags = 0;
        pair_tag = 0;
        burst_left = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        send_pair(0, 0, 0, 2 * ONE, 2 * ONE, 0, ONE, ONE, 2 * ONE, 2 * ONE);
        send_pair(0, 0, 0, 4 * ONE, 2 * ONE, 0, ONE, 0, 2 * ONE, 4 * ONE);
        send_pair(0, 0, 0, 2 * ONE, 2 * ONE, 0, 0, 0, 2 * ONE, 2 * ONE);
        send_pair(0, 0, 0, 2 * ONE, 2 * ONE, 0, 2 * ONE, 0, 2 * ONE, 2 * ONE);
        send_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_pair(0, 0, 0, 0, 0, 0, ONE, -ONE, 4 * ONE, 4 * ONE);
        send_pair(0, MINC, MINC, MAXE, MAXE, 0, MAXE, MAXE, MAXE, MAXE);
        send_pair(0, 0, 0, MAXE, MAXE, 0, 0, 0, MAXE, MAXE);
        send_pair(1, 0, 0, ONE, 0, 1, ONE, ONE, ONE, 0);
        send_pair(1, 0, 0, ONE, 0, 1, 0, 0, ONE, 0);
        send_pair(1, 0, 0, ONE, 0, 1, 30, -20, ONE, 0);
        send_pair(1, 0, 0, 0, 0, 1, 0, 0, 0, 0);
        send_pair(1, 0, 0, MAXE, MAXE, 1, 0, 5, MAXE, 0);
        send_pair(1, MINC, MINC, MAXE, 0, 1, MAXE, MAXE, MAXE, 0);
        send_pair(0, 0, 0, 2 * ONE, 2 * ONE, 1, 3 * ONE / 2, ONE / 2, ONE, 0);
        send_pair(1, 3 * ONE / 2, ONE / 2, ONE, 0, 0, 0, 0, 2 * ONE, 2 * ONE);
        send_pair(0, 0, 0, 4 * ONE, 4 * ONE, 1, ONE / 4, ONE / 2, ONE, 0);
        send_pair(1, 0, 0, ONE, 0, 0, 0, 0, 4 * ONE, 4 * ONE);
        send_pair(0, 0, 0, 2 * ONE, 2 * ONE, 1, 2 * ONE, 2 * ONE, 2 * ONE, 0);
        send_pair(1, -ONE, 0, 0, 0, 0, 0, 0, 2 * ONE, 2 * ONE);
        send_pair(0, MAXE, MINC, MAXE, MAXE, 1, MINC, MAXE, MAXE, MAXE);
        send_pair(1, MAXE, MAXE, MAXE, MAXE, 0, MAXE, MAXE, MAXE, MAXE);

        repeat (RANDOM_PAIRS)
            send_random_pair();

        @(negedge clk);
        start = 0;
        while (in_flight != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (fail_count == 0)
            $display("PASS shape_pair_contact_test_top");
        else
            $display("FAIL shape_pair_contact_test_top");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/spct_pkg.sv
rtl/core/spct_prep.sv
rtl/core/spct_isqrt.sv
rtl/core/spct_div.sv
rtl/core/shape_pair_contact_test_top.sv
sim/contact_checker.sv
sim/shape_pair_contact_test_top_tb.sv
